/* sv/tsbf_pkg.sv */
// Package: shared types and constants of the turn signal button decision block.
`timescale 1ns / 1ps

package tsbf_pkg;

  // Input event codes
  typedef enum logic [1:0] {
    ACT_LEFT  = 2'd0,
    ACT_RIGHT = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  // Configuration register indexes
  localparam logic [7:0] REG_MAX_WAIT   = 8'd0;
  localparam logic [7:0] REG_LONG_PRESS = 8'd1;

  localparam logic [15:0] MAX_WAIT_RESET   = 16'd2000;
  localparam logic [7:0]  LONG_PRESS_RESET = 8'd9;

  typedef struct packed {
    logic [1:0]  action;
    logic        left_held;
    logic        right_held;
    logic        hazard_on;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic toggle_left;
    logic toggle_right;
    logic toggle_hazard;
    logic overtake_valid;
    logic overtake_value;
    logic timed_out;
  } result_t;

  typedef struct packed {
    logic [15:0] max_wait_ms;
    logic [7:0]  long_press_ticks;
  } cfg_t;

endpackage

/* sv/tsbf_if.sv */
// Interfaces: event input, result output and configuration write channels.
`timescale 1ns / 1ps

interface tsbf_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        left_held;
  logic        right_held;
  logic        hazard_on;
  logic [31:0] now_ms;

  modport source (output valid, action, left_held, right_held, hazard_on, now_ms,
                  input ready);
  modport sink   (input valid, action, left_held, right_held, hazard_on, now_ms,
                  output ready);
endinterface

interface tsbf_res_if;
  logic valid;
  logic ready;
  logic toggle_left;
  logic toggle_right;
  logic toggle_hazard;
  logic overtake_valid;
  logic overtake_value;
  logic timed_out;

  modport source (output valid, toggle_left, toggle_right, toggle_hazard,
                  overtake_valid, overtake_value, timed_out, input ready);
  modport sink   (input valid, toggle_left, toggle_right, toggle_hazard,
                  overtake_valid, overtake_value, timed_out, output ready);
endinterface

interface tsbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tsbf_cfg_regs.sv */
// Configuration registers: maximum wait and long press tick count.
`timescale 1ns / 1ps

module tsbf_cfg_regs
  import tsbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_wait_ms      <= MAX_WAIT_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_WAIT:   cfg.max_wait_ms      <= wr_data;
        REG_LONG_PRESS: cfg.long_press_ticks <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/tsbf_decide.sv */
// Decision logic: window state registers and per-event result.
`timescale 1ns / 1ps

module tsbf_decide
  import tsbf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic        left_pending, left_pending_next;
  logic        right_pending, right_pending_next;
  logic        awaiting_long, awaiting_long_next;
  logic        window_running, window_running_next;
  logic [7:0]  long_count, long_count_next;
  logic [31:0] window_start, window_start_next;
  logic [31:0] elapsed;
  logic        side_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pending   <= 1'b0;
      right_pending  <= 1'b0;
      awaiting_long  <= 1'b0;
      window_running <= 1'b0;
      long_count     <= 8'd0;
      window_start   <= 32'd0;
    end else if (fire) begin
      left_pending   <= left_pending_next;
      right_pending  <= right_pending_next;
      awaiting_long  <= awaiting_long_next;
      window_running <= window_running_next;
      long_count     <= long_count_next;
      window_start   <= window_start_next;
    end
  end

  assign elapsed = item.now_ms - window_start;

  always_comb begin
    left_pending_next   = left_pending;
    right_pending_next  = right_pending;
    awaiting_long_next  = awaiting_long;
    window_running_next = window_running;
    long_count_next     = long_count;
    window_start_next   = window_start;
    res                 = '0;
    side_pending        = 1'b0;

    case (action_t'(item.action))
      ACT_LEFT, ACT_RIGHT: begin
        side_pending = (item.action == ACT_LEFT) ? left_pending : right_pending;
        if (!side_pending) begin
          // First press of an idle block opens the window
          if (!left_pending && !right_pending) begin
            window_start_next   = item.now_ms;
            window_running_next = 1'b1;
          end
          if (item.action == ACT_LEFT) left_pending_next = 1'b1;
          else                         right_pending_next = 1'b1;
        end
      end
      ACT_TICK: begin
        if (window_running) begin
          // Default for every branch that closes the window
          left_pending_next   = 1'b0;
          right_pending_next  = 1'b0;
          awaiting_long_next  = 1'b0;
          window_running_next = 1'b0;
          long_count_next     = 8'd0;
          if ({16'd0, cfg.max_wait_ms} <= elapsed) begin
            res.timed_out = 1'b1;
          end else if (awaiting_long) begin
            if (long_count < cfg.long_press_ticks) begin
              // Keep waiting: restore the window
              left_pending_next   = left_pending;
              right_pending_next  = right_pending;
              awaiting_long_next  = 1'b1;
              window_running_next = 1'b1;
              long_count_next     = long_count + 8'd1;
            end else begin
              res.overtake_valid = 1'b1;
              res.overtake_value = !(item.left_held || item.right_held);
            end
          end else if (item.left_held && item.right_held) begin
            res.toggle_hazard = 1'b1;
          end else if (!item.hazard_on && item.left_held) begin
            res.toggle_left     = 1'b1;
            right_pending_next  = right_pending;
            awaiting_long_next  = 1'b1;
            window_running_next = 1'b1;
            long_count_next     = long_count;
            window_start_next   = item.now_ms;
          end else if (!item.hazard_on && item.right_held) begin
            res.toggle_right    = 1'b1;
            left_pending_next   = left_pending;
            awaiting_long_next  = 1'b1;
            window_running_next = 1'b1;
            long_count_next     = long_count;
            window_start_next   = item.now_ms;
          end else if (!item.hazard_on && left_pending) begin
            res.toggle_left = 1'b1;
          end else if (!item.hazard_on && right_pending) begin
            res.toggle_right = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/turn_signal_button_fsm.sv */
// Top level: turn signal button decision block with registered input and result.
`timescale 1ns / 1ps
// An accepted event transaction is held in the input register, then the decision logic
//   loads its result into the result register, which presents it on res.
// Throughput: one event transaction per cycle while res.ready is high; the decision logic is combinational.
// Reset (rst, synchronous, active high) empties both stages, clears the window state
//   and loads max_wait_ms = 2000 and long_press_ticks = 9.

module turn_signal_button_fsm
  import tsbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tsbf_evt_if.sink          evt,
  tsbf_res_if.source        res,
  tsbf_cfg_if.sink          cfg
);

  // Input stage
  logic    s1_valid;
  item_t   s1_item;

  // Result register
  logic    out_valid;
  result_t out_res;

  logic    out_free;
  logic    advance;
  result_t dec_res;
  cfg_t    cfg_q;

  // Result register can take a new value when empty or being drained
  assign out_free  = !out_valid || res.ready;
  // Move the held event through the decision logic
  assign advance   = s1_valid && out_free;
  // Accept a new event whenever the input stage empties this cycle
  assign evt.ready = !s1_valid || out_free;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  tsbf_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  tsbf_decide u_decide (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .cfg  (cfg_q),
    .res  (dec_res)
  );

  // Control: hold valid flags until their transactions move on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (evt.valid && evt.ready) s1_valid <= 1'b1;
      else if (advance)           s1_valid <= 1'b0;

      if (advance)        out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  // Payload: capture the event and the decided result
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_item.action     <= evt.action;
      s1_item.left_held  <= evt.left_held;
      s1_item.right_held <= evt.right_held;
      s1_item.hazard_on  <= evt.hazard_on;
      s1_item.now_ms     <= evt.now_ms;
    end
    if (advance) out_res <= dec_res;
  end

  assign res.valid          = out_valid;
  assign res.toggle_left    = out_res.toggle_left;
  assign res.toggle_right   = out_res.toggle_right;
  assign res.toggle_hazard  = out_res.toggle_hazard;
  assign res.overtake_valid = out_res.overtake_valid;
  assign res.overtake_value = out_res.overtake_value;
  assign res.timed_out      = out_res.timed_out;

endmodule

/* tb/testbench.sv */
// Testbench for turn_signal_button_fsm: random button/tick traffic against a decision predictor.
`timescale 1ns / 1ps

module testbench;
  import tsbf_pkg::*;

  // Action code with no meaning; the block must answer it with an all-zero result.
  localparam logic [1:0] ACT_NONE = 2'd3;
  // Register indexes past the map; writes to them must change nothing.
  localparam logic [7:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [7:0] REG_UNMAPPED_HI = 8'hFF;
  localparam int TICK_MS     = 110;
  localparam int HOLD_CYCLES = 64;    // long receiver hold-off that backs up the pipeline
  localparam int STALL_LIMIT = 1000;  // cycles with no transaction anywhere before giving up

  // Predicts the decision of every event and keeps the decisions still awaited.
  class decision_board;
    logic [15:0] max_wait;
    logic [7:0]  long_ticks;
    bit          left_pend;
    bit          right_pend;
    bit          await_long;
    bit          running;
    logic [7:0]  long_cnt;
    logic [31:0] start_ms;
    result_t     awaited_q[$];
    int          errors;

    function new();
      max_wait   = MAX_WAIT_RESET;
      long_ticks = LONG_PRESS_RESET;
      left_pend  = 1'b0;
      right_pend = 1'b0;
      await_long = 1'b0;
      running    = 1'b0;
      long_cnt   = '0;
      start_ms   = '0;
      errors     = 0;
    endfunction

    function void apply_config(logic [7:0] idx, logic [15:0] val);
      if (idx == REG_MAX_WAIT) max_wait = val;
      else if (idx == REG_LONG_PRESS) long_ticks = val[7:0];
    endfunction

    // The start time survives the end of a window.
    function void close_window();
      running    = 1'b0;
      await_long = 1'b0;
      left_pend  = 1'b0;
      right_pend = 1'b0;
      long_cnt   = '0;
    endfunction

    function void note_item(item_t it);
      result_t     r;
      logic [31:0] elapsed;
      r = '0;
      if (it.action == ACT_LEFT || it.action == ACT_RIGHT) begin
        if ((it.action == ACT_LEFT) ? !left_pend : !right_pend) begin
          if (!left_pend && !right_pend) begin
            start_ms = it.now_ms;
            running  = 1'b1;
          end
          if (it.action == ACT_LEFT) left_pend = 1'b1;
          else right_pend = 1'b1;
        end
      end else if (it.action == ACT_TICK && running) begin
        elapsed = it.now_ms - start_ms;
        if ({16'd0, max_wait} <= elapsed) begin
          r.timed_out = 1'b1;
          close_window();
        end else if (await_long) begin
          if (long_cnt < long_ticks) begin
            long_cnt = long_cnt + 8'd1;
          end else begin
            r.overtake_valid = 1'b1;
            r.overtake_value = !(it.left_held || it.right_held);
            close_window();
          end
        end else if (it.left_held && it.right_held) begin
          r.toggle_hazard = 1'b1;
          close_window();
        end else if (!it.hazard_on && it.left_held) begin
          left_pend     = 1'b0;
          r.toggle_left = 1'b1;
          await_long    = 1'b1;
          start_ms      = it.now_ms;
          running       = 1'b1;
        end else if (!it.hazard_on && it.right_held) begin
          right_pend     = 1'b0;
          r.toggle_right = 1'b1;
          await_long     = 1'b1;
          start_ms       = it.now_ms;
          running        = 1'b1;
        end else if (!it.hazard_on && left_pend) begin
          r.toggle_left = 1'b1;
          close_window();
        end else if (!it.hazard_on && right_pend) begin
          r.toggle_right = 1'b1;
          close_window();
        end else begin
          close_window();
        end
      end
      awaited_q.push_back(r);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, actual %0b", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_q.size() == 0) begin
        $error("result transaction with no decision awaited");
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      compare_bit("toggle_left", want.toggle_left, got.toggle_left);
      compare_bit("toggle_right", want.toggle_right, got.toggle_right);
      compare_bit("toggle_hazard", want.toggle_hazard, got.toggle_hazard);
      compare_bit("overtake_valid", want.overtake_valid, got.overtake_valid);
      compare_bit("overtake_value", want.overtake_value, got.overtake_value);
      compare_bit("timed_out", want.timed_out, got.timed_out);
    endfunction
  endclass

  logic clk;
  logic rst;

  tsbf_evt_if evt ();
  tsbf_res_if res ();
  tsbf_cfg_if cfg ();

  turn_signal_button_fsm u_top (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  decision_board sb;
  bit            gaps_on;    // random idling on both sides
  bit            hold_req;   // ask the receiver for one long hold-off
  int            items_sent;
  int            quiet_cycles;
  logic [31:0]   clock_ms;   // running millisecond time seen by the block

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result monitor: sample at the rising edge, check against the oldest decision.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result({res.toggle_left, res.toggle_right, res.toggle_hazard,
                       res.overtake_valid, res.overtake_value, res.timed_out});
  end

  // Watchdog: drop the run when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (res.valid && res.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: drive ready at the falling edge. A hold request drops ready for a
  // long stretch counted here; otherwise stall in short random bursts while
  // idling is enabled, and stay ready when it is not.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res.ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  function automatic item_t pack_item(logic [1:0] act, bit l, bit r, bit h, logic [31:0] t);
    item_t it;
    it.action     = act;
    it.left_held  = l;
    it.right_held = r;
    it.hazard_on  = h;
    it.now_ms     = t;
    return it;
  endfunction

  // Offer one event at the falling edge, optionally after a short idle burst,
  // and hold it until the block takes it. Returns at the accepting edge, so
  // valid stays high into the next item unless the caller drops it.
  task automatic send_item(item_t it);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      evt.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    evt.valid      = 1'b1;
    evt.action     = it.action;
    evt.left_held  = it.left_held;
    evt.right_held = it.right_held;
    evt.hazard_on  = it.hazard_on;
    evt.now_ms     = it.now_ms;
    do @(posedge clk); while (!evt.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Stop offering and wait until every decision has come back, plus the
  // pipeline depth, so the block is idle.
  task automatic settle();
    @(negedge clk);
    evt.valid = 1'b0;
    while (sb.awaited_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    do @(posedge clk); while (!cfg.ready);
    sb.apply_config(idx, val);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // One press of a button (sometimes both) followed by the 110 ms ticks a real
  // timer would give. The held levels follow a hold length in ticks: zero
  // means released before the first tick, a short one ends up in overtake
  // mode, a long one in regular signalling.
  task automatic press_run();
    bit both;
    bit right_first;
    bit hz;
    bit a_held;
    bit b_held;
    int hold_a;
    int hold_b;
    int n_ticks;
    int k;
    int lp;
    lp          = sb.long_ticks;
    both        = ($urandom_range(0, 4) == 0);
    right_first = 1'($urandom_range(0, 1));
    hz          = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 2))
      0: hold_a = 0;
      1: hold_a = $urandom_range(1, lp + 1);
      default: hold_a = lp + 2 + $urandom_range(0, 3);
    endcase
    hold_b = both ? $urandom_range(0, hold_a + 1) : 0;
    if (lp + 4 <= 40 && $urandom_range(0, 3) != 0) n_ticks = lp + 2 + $urandom_range(0, 2);
    else n_ticks = $urandom_range(1, 40);

    clock_ms += $urandom_range(1, 400);
    send_item(pack_item(right_first ? ACT_RIGHT : ACT_LEFT, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), hz, clock_ms));
    // Bounce: another edge on a side that is already pending.
    if ($urandom_range(0, 5) == 0)
      send_item(pack_item(right_first ? ACT_RIGHT : ACT_LEFT, 1'b1, 1'b1, hz,
                          clock_ms + $urandom_range(0, 50)));
    if (both) begin
      clock_ms += $urandom_range(0, 60);
      send_item(pack_item(right_first ? ACT_LEFT : ACT_RIGHT, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), hz, clock_ms));
    end
    for (k = 1; k <= n_ticks; k++) begin
      // Mostly a steady tick; now and then a late one to push toward the timeout.
      if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(0, 2500);
      else clock_ms += TICK_MS;
      a_held = (k <= hold_a);
      b_held = (k <= hold_b);
      send_item(pack_item(ACT_TICK, right_first ? b_held : a_held,
                          right_first ? a_held : b_held, hz, clock_ms));
    end
  endtask

  // Anything at all, including the unused action code and arbitrary times.
  task automatic send_noise();
    logic [1:0] act;
    act = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 500);
    send_item(pack_item(act, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), clock_ms));
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) send_noise();
      else press_run();
    end
  endtask

  task automatic run_phase(logic [15:0] max_wait, logic [7:0] long_ticks, int count);
    settle();
    cfg_write(REG_MAX_WAIT, max_wait);
    cfg_write(REG_LONG_PRESS, {8'd0, long_ticks});
    run_random(count);
  endtask

  // Directed opening at the reset settings (2000 ms, 9 ticks).
  task automatic directed_checks();
    int k;
    // Tick with no window open: ignored.
    send_item(pack_item(ACT_TICK, 1'b1, 1'b1, 1'b0, 32'd0));
    // Unused action code with every field at its top.
    send_item(pack_item(ACT_NONE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    // Right press, a bounce on the pending side, then released before the tick.
    send_item(pack_item(ACT_RIGHT, 1'b0, 1'b0, 1'b0, 32'd1000));
    send_item(pack_item(ACT_RIGHT, 1'b1, 1'b1, 1'b1, 32'd1020));
    send_item(pack_item(ACT_TICK, 1'b0, 1'b0, 1'b0, 32'd1110));
    // Both buttons held on the tick: hazard toggle.
    send_item(pack_item(ACT_LEFT, 1'b1, 1'b0, 1'b0, 32'd2000));
    send_item(pack_item(ACT_RIGHT, 1'b1, 1'b1, 1'b0, 32'd2050));
    send_item(pack_item(ACT_TICK, 1'b1, 1'b1, 1'b0, 32'd2110));
    // Hazard already on: the tick just closes the window.
    send_item(pack_item(ACT_LEFT, 1'b1, 1'b0, 1'b1, 32'd3000));
    send_item(pack_item(ACT_TICK, 1'b1, 1'b0, 1'b1, 32'd3110));
    // Elapsed exactly the maximum wait: timeout.
    send_item(pack_item(ACT_RIGHT, 1'b0, 1'b1, 1'b0, 32'd4000));
    send_item(pack_item(ACT_TICK, 1'b0, 1'b1, 1'b0, 32'd6000));
    // Press just before the time wraps, held toggle after the wrap, then the
    // long-press count and a release: overtake mode.
    send_item(pack_item(ACT_LEFT, 1'b1, 1'b0, 1'b0, 32'hFFFF_FF00));
    send_item(pack_item(ACT_TICK, 1'b1, 1'b0, 1'b0, 32'h0000_003C));
    for (k = 1; k <= 10; k++)
      send_item(pack_item(ACT_TICK, k < 10, 1'b0, 1'b0, 32'h3C + TICK_MS * k));
  endtask

  initial begin
    sb             = new();
    gaps_on        = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    quiet_cycles   = 0;
    evt.valid      = 1'b0;
    evt.action     = ACT_LEFT;
    evt.left_held  = 1'b0;
    evt.right_held = 1'b0;
    evt.hazard_on  = 1'b0;
    evt.now_ms     = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_MAX_WAIT;
    cfg.data       = '0;
    rst            = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_checks();
    clock_ms = $urandom;
    gaps_on  = 1'b1;

    // Reset settings; partway through, hold off the receiver while events keep coming.
    run_phase(16'd2000, 8'd9, 40);
    hold_req = 1'b1;
    run_random(80);

    // One-millisecond wait and no long-press count.
    run_phase(16'd1, 8'd0, 40);
    // Widest settings.
    run_phase(16'd65535, 8'd255, 40);
    // Zero wait: every running tick times out. Writes past the map are ignored.
    settle();
    cfg_write(REG_UNMAPPED_LO, 16'($urandom));
    cfg_write(REG_UNMAPPED_HI, 16'($urandom));
    run_phase(16'd0, 8'd3, 25);

    // Middle settings; the tail runs with no idling on either side.
    run_phase(16'd700, 8'd4, 40);
    gaps_on = 1'b0;
    run_random(40);

    settle();
    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
